// File: src/csas_pkg.sv
package csas_pkg;

  typedef struct packed {
    logic [7:0] sample;
    logic       last_sample;
  } in_word_t;

  typedef struct packed {
    logic [7:0]  axis_index;
    logic [63:0] min_deviation;
    logic [63:0] mean_deviation;
    logic        too_short;
  } out_word_t;

  localparam int SAMPLE_W = 8;
  localparam int SUM_W = 64;
  localparam logic [SUM_W-1:0] SUM_MAX = '1;

  // Controller to datapath.
  typedef struct packed {
    logic store;
    logic clear_cnt;
    logic start_search;
    logic start_axis;
    logic rd_issue;
    logic pw_step;
    logic acc_step;
    logic close_axis;
    logic start_div;
    logic div_step;
    logic load_out;
    logic load_short;
  } csas_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic short_ring;
    logic last_j;
    logic last_axis;
    logic div_done;
  } csas_sts_t;

endpackage

// File: src/csas_datapath.sv
module csas_datapath
  import csas_pkg::*;
#(
  parameter int MAX_SAMPLES = 512
) (
  input  logic      clk,
  input  logic      rst_n,
  input  in_word_t  in_word,
  input  csas_cmd_t cmd,
  output csas_sts_t sts,
  output out_word_t out_word
);

  localparam int AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int CW = $clog2(MAX_SAMPLES + 1);

  logic [SAMPLE_W-1:0] mem [MAX_SAMPLES];
  logic [SAMPLE_W-1:0] rd_a_r, rd_b_r;

  logic [CW-1:0] cnt_r, n_r;
  logic [CW-1:0] i_r, j_r;
  logic [AW-1:0] pa_r, pb_r;
  logic [CW-1:0] half;

  logic [15:0] d2_r;
  logic [31:0] d4_r;
  logic [63:0] d8_r;
  logic [1:0]  pw_ph_r;

  logic [SUM_W-1:0] acc_r, best_r, total_r;
  logic [7:0] best_axis_r;

  logic [SUM_W-1:0] quo_r, rem_r;
  logic [6:0] div_cnt_r;
  out_word_t out_r;

  assign half = n_r >> 1;

  always_ff @(posedge clk) begin
    if (cmd.store && (cnt_r < CW'(MAX_SAMPLES))) begin
      mem[cnt_r[AW-1:0]] <= in_word.sample;
    end
    rd_a_r <= mem[pa_r];
    rd_b_r <= mem[pb_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.store) begin
      if (cmd.clear_cnt) begin
        cnt_r <= '0;
      end else if (cnt_r < CW'(MAX_SAMPLES)) begin
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  logic [CW-1:0] cnt_after;
  assign cnt_after = (cnt_r < CW'(MAX_SAMPLES)) ? cnt_r + 1'b1 : cnt_r;

  logic [CW:0] sum_ij;
  logic [CW:0] nxt_a, nxt_b;
  always_comb begin
    sum_ij = (CW+1)'(pa_r) + 1'b1;
    nxt_a = (sum_ij >= {1'b0, n_r}) ? '0 : sum_ij;
    nxt_b = (pb_r == '0) ? {1'b0, n_r} - 1'b1 : (CW+1)'(pb_r) - 1'b1;
  end

  logic [SAMPLE_W-1:0] diff;
  assign diff = (rd_a_r >= rd_b_r) ? rd_a_r - rd_b_r : rd_b_r - rd_a_r;

  logic [SUM_W:0] acc_sum, tot_sum;
  assign acc_sum = {1'b0, acc_r} + {1'b0, d8_r};
  assign tot_sum = {1'b0, total_r} + {1'b0, acc_r};

  logic [SUM_W:0] rem_sh;
  assign rem_sh = {rem_r, quo_r[SUM_W-1]};

  always_ff @(posedge clk) begin
    if (cmd.store && in_word.last_sample) begin
      n_r <= cnt_after;
    end
    if (cmd.start_search) begin
      i_r <= '0;
      total_r <= '0;
      best_r <= '0;
      best_axis_r <= '0;
    end
    if (cmd.start_axis) begin
      j_r <= '0;
      acc_r <= '0;
      pa_r <= i_r[AW-1:0];
      pb_r <= i_r[AW-1:0];
    end
    if (cmd.rd_issue) begin
      pa_r <= nxt_a[AW-1:0];
      pb_r <= nxt_b[AW-1:0];
      pw_ph_r <= '0;
    end
    if (cmd.pw_step) begin
      unique case (pw_ph_r)
        2'd0: d2_r <= 16'(diff) * 16'(diff);
        2'd1: d4_r <= 32'(d2_r) * 32'(d2_r);
        2'd2: d8_r <= 64'(d4_r) * 64'(d4_r);
        default: d8_r <= d8_r;
      endcase
      pw_ph_r <= pw_ph_r + 1'b1;
    end
    if (cmd.acc_step) begin
      acc_r <= acc_sum[SUM_W] ? SUM_MAX : acc_sum[SUM_W-1:0];
      j_r <= j_r + 1'b1;
    end
    if (cmd.close_axis) begin
      if ((i_r == '0) || (acc_r < best_r)) begin
        best_r <= acc_r;
        best_axis_r <= 8'(i_r);
      end
      total_r <= tot_sum[SUM_W] ? SUM_MAX : tot_sum[SUM_W-1:0];
      i_r <= i_r + 1'b1;
    end
    if (cmd.start_div) begin
      quo_r <= total_r;
      rem_r <= '0;
      div_cnt_r <= '0;
    end
    if (cmd.div_step) begin
      if (rem_sh >= {{(SUM_W+1-CW){1'b0}}, half}) begin
        rem_r <= SUM_W'(rem_sh - {{(SUM_W+1-CW){1'b0}}, half});
        quo_r <= {quo_r[SUM_W-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh[SUM_W-1:0];
        quo_r <= {quo_r[SUM_W-2:0], 1'b0};
      end
      div_cnt_r <= div_cnt_r + 1'b1;
    end
    if (cmd.load_out) begin
      out_r.axis_index <= best_axis_r;
      out_r.min_deviation <= best_r;
      out_r.mean_deviation <= quo_r;
      out_r.too_short <= 1'b0;
    end
    if (cmd.load_short) begin
      out_r <= '{axis_index: '0, min_deviation: '0, mean_deviation: '0, too_short: 1'b1};
    end
  end

  assign sts.short_ring = (cnt_after < CW'(2));
  assign sts.last_j = (j_r + 1'b1 == half);
  assign sts.last_axis = (i_r + 1'b1 == half);
  assign sts.div_done = (div_cnt_r == 7'(SUM_W - 1));
  assign out_word = out_r;

endmodule

// File: src/csas_ctrl.sv
module csas_ctrl
  import csas_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_last,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  csas_sts_t sts,
  output csas_cmd_t cmd
);

  typedef enum logic [9:0] {
    S_LOAD   = 10'b0000000001,
    S_AXIS   = 10'b0000000010,
    S_READ   = 10'b0000000100,
    S_WAIT   = 10'b0000001000,
    S_POW    = 10'b0000010000,
    S_ACC    = 10'b0000100000,
    S_CLOSE  = 10'b0001000000,
    S_DIVI   = 10'b0010000000,
    S_DIV    = 10'b0100000000,
    S_OUT    = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;
  logic [1:0] ph_r, ph_nxt;
  logic out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      ph_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ph_r <= ph_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  logic take;
  assign in_ready = (state_r == S_LOAD) && !out_valid_r;
  assign take = in_valid && in_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    ph_nxt = ph_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd = '0;
    unique case (state_r)
      S_LOAD: begin
        if (take) begin
          cmd.store = 1'b1;
          if (in_last) begin
            cmd.clear_cnt = 1'b1;
            if (sts.short_ring) begin
              cmd.load_short = 1'b1;
              out_valid_nxt = 1'b1;
            end else begin
              cmd.start_search = 1'b1;
              state_nxt = S_AXIS;
            end
          end
        end
      end
      S_AXIS: begin
        cmd.start_axis = 1'b1;
        state_nxt = S_READ;
      end
      S_READ: begin
        state_nxt = S_WAIT;
      end
      S_WAIT: begin
        cmd.rd_issue = 1'b1;
        state_nxt = S_POW;
      end
      S_POW: begin
        cmd.pw_step = 1'b1;
        ph_nxt = ph_r + 1'b1;
        if (ph_r == 2'd2) begin
          ph_nxt = '0;
          state_nxt = S_ACC;
        end
      end
      S_ACC: begin
        cmd.acc_step = 1'b1;
        state_nxt = sts.last_j ? S_CLOSE : S_WAIT;
      end
      S_CLOSE: begin
        cmd.close_axis = 1'b1;
        state_nxt = sts.last_axis ? S_DIVI : S_AXIS;
      end
      S_DIVI: begin
        cmd.start_div = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        cmd.load_out = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt = S_LOAD;
      end
      default: state_nxt = S_LOAD;
    endcase
  end

endmodule

// File: src/contour_symmetry_axis_search_top.sv
// Takes one sample word per cycle until the word flagged last_sample, then
// searches H = N/2 candidate axes with one shared eighth-power unit: each of
// the H*H difference terms passes through read, square, square, square and
// accumulate steps, each axis adds its own start, read and close steps, and a
// bit-serial divider forms the mean.
// Input is held off until the result word has been taken.
module contour_symmetry_axis_search_top
  import csas_pkg::*;
#(
  parameter int MAX_SAMPLES = 512
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  csas_cmd_t cmd;
  csas_sts_t sts;

  csas_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_last(in_data.last_sample), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready),
    .sts(sts), .cmd(cmd)
  );

  csas_datapath #(.MAX_SAMPLES(MAX_SAMPLES)) u_dp (
    .clk(clk), .rst_n(rst_n),
    .in_word(in_data), .cmd(cmd), .sts(sts), .out_word(out_data)
  );

endmodule

// File: src/csas_checker.sv
module csas_checker
  import csas_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input in_word_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input out_word_t out_data
);

  a_no_in_with_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input taken while result pending");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  a_short_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.too_short |-> out_data.min_deviation == '0 &&
    out_data.axis_index == '0) else $error("short ring result not zero");

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("input word changed while stalled");

endmodule

bind contour_symmetry_axis_search_top csas_checker u_csas_checker (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
  .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);
